/* hdl/fbpa_pkg.sv */
// Shared types and constants for the fixed block pool allocator.
`default_nettype none
package fbpa_pkg;

  localparam int ROW_BITS = 16;
  localparam int BIT_W    = 4;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

  localparam logic [31:0] RST_POOL_BASE   = 32'd0;
  localparam logic [15:0] RST_BLOCK_SIZE  = 16'd64;
  localparam logic [6:0]  RST_BLOCK_COUNT = 7'd64;

  typedef struct packed {
    logic        op;
    logic [31:0] block_address;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] granted_address;
    logic [5:0]  block_index;
  } out_word_t;

endpackage
`default_nettype wire

/* hdl/fixed_block_pool_allocator.sv */
// Fixed-size block pool allocator: used-bit map in RAM, free count, get and put.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+----------------------------------
//   in      | start, busy, in_data           | word taken when start & !busy
//   out     | out_valid, out_data            | one-cycle strobe, no back-pressure
//   cfg     | cfg_we, cfg_index, cfg_data    | write taken when cfg_we
//
// Get: scans the map one 16-entry row at a time, then multiplies to form the address;
// a scan with no free bit answers from the scan state. Put: a 7-step restoring divide
// of the offset gives the index; an index above 127 is refused before the divide, an
// index past the pool after it. Requests rejected at acceptance answer in the next
// cycle. Results cannot be stalled. Reset and every block_count write run a clearing
// pass over every map RAM row, with busy high; config writes are still taken.
`default_nettype none
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire fbpa_pkg::in_word_t            in_data,
  output      logic                          out_valid,
  output      fbpa_pkg::out_word_t           out_data,
  input  wire logic                          cfg_we,
  input  wire logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  localparam int ROWS  = (MAX_BLOCKS + fbpa_pkg::ROW_BITS - 1) / fbpa_pkg::ROW_BITS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W = RW + fbpa_pkg::BIT_W;
  localparam int CMP_W = (IDX_W > 7) ? IDX_W + 1 : 8;
  localparam int CAP   = (MAX_BLOCKS > 127) ? 127 : MAX_BLOCKS;
  localparam logic [6:0] CAP7 = 7'(CAP);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam int PW    = 16 + IDX_W;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_G_WAIT, ST_G_SCAN, ST_G_MUL, ST_G_ADD,
    ST_P_CHK, ST_P_DIV, ST_P_IDX, ST_P_WAIT, ST_P_WR
  } st_t;

  function automatic logic [6:0] clamp_total(input logic [6:0] bc);
    logic [6:0] t;
    t = bc;
    if (bc == 7'd0) t = 7'd1;
    else if (bc > CAP7) t = CAP7;
    return t;
  endfunction

  st_t                          state_r;
  logic [31:0]                  pool_base_r;
  logic [15:0]                  block_size_r;
  logic [6:0]                   block_count_r;
  logic [6:0]                   free_count_r;
  logic [RW-1:0]                row_r;
  logic [fbpa_pkg::ROW_BITS-1:0] mem [ROWS];
  logic [fbpa_pkg::ROW_BITS-1:0] rd_data_r;
  logic [31:0]                  offset_r;
  logic [22:0]                  rem_r;
  logic [22:0]                  dsh_r;
  logic [6:0]                   q_r;
  logic [2:0]                   step_r;
  logic [IDX_W-1:0]             idx_r;
  logic [PW-1:0]                prod_r;
  logic                         out_valid_r;
  fbpa_pkg::out_word_t          out_data_r;

  logic [6:0]                   total;
  logic [15:0]                  size_eff;
  logic [fbpa_pkg::ROW_BITS-1:0] avail;
  logic                         found;
  logic [fbpa_pkg::BIT_W-1:0]   found_bit;
  logic                         last_row;
  logic [IDX_W-1:0]             put_idx;
  logic                         mem_we;
  logic [fbpa_pkg::ROW_BITS-1:0] mem_wdata;

  assign total    = clamp_total(block_count_r);
  assign size_eff = (block_size_r == 16'd0) ? 16'd1 : block_size_r;
  assign put_idx  = IDX_W'(q_r);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    for (int b = 0; b < fbpa_pkg::ROW_BITS; b++) begin
      avail[b] = !rd_data_r[b] &&
                 (CMP_W'({row_r, fbpa_pkg::BIT_W'(b)}) < CMP_W'(total));
    end
    found     = 1'b0;
    found_bit = '0;
    for (int b = fbpa_pkg::ROW_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        found     = 1'b1;
        found_bit = fbpa_pkg::BIT_W'(b);
      end
    end
    last_row = (row_r == LAST_ROW) ||
               (CMP_W'({row_r, fbpa_pkg::BIT_W'(0)}) + CMP_W'(fbpa_pkg::ROW_BITS)
                >= CMP_W'(total));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    unique case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_G_SCAN: begin
        mem_we    = found;
        mem_wdata = rd_data_r | (fbpa_pkg::ROW_BITS'(1) << found_bit);
      end
      ST_P_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_r &
                    ~(fbpa_pkg::ROW_BITS'(1) << put_idx[fbpa_pkg::BIT_W-1:0]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[row_r] <= mem_wdata;
    end
    rd_data_r <= mem[row_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      pool_base_r   <= fbpa_pkg::RST_POOL_BASE;
      block_size_r  <= fbpa_pkg::RST_BLOCK_SIZE;
      block_count_r <= fbpa_pkg::RST_BLOCK_COUNT;
      free_count_r  <= clamp_total(fbpa_pkg::RST_BLOCK_COUNT);
      row_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLR: begin
          if (row_r == LAST_ROW) begin
            state_r <= ST_IDLE;
            row_r   <= '0;
          end else begin
            row_r <= row_r + RW'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            if (in_data.op == fbpa_pkg::OP_GET) begin
              if (free_count_r == 7'd0) begin
                out_valid_r <= 1'b1;
                out_data_r  <= '0;
              end else begin
                row_r   <= '0;
                state_r <= ST_G_WAIT;
              end
            end else begin
              if (free_count_r >= total || in_data.block_address < pool_base_r) begin
                out_valid_r <= 1'b1;
                out_data_r  <= '0;
              end else begin
                offset_r <= in_data.block_address - pool_base_r;
                state_r  <= ST_P_CHK;
              end
            end
          end
        end
        ST_G_WAIT: begin
          state_r <= ST_G_SCAN;
        end
        ST_G_SCAN: begin
          if (found) begin
            idx_r        <= {row_r, found_bit};
            free_count_r <= free_count_r - 7'd1;
            state_r      <= ST_G_MUL;
          end else if (last_row) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '0;
            state_r     <= ST_IDLE;
          end else begin
            row_r   <= row_r + RW'(1);
            state_r <= ST_G_WAIT;
          end
        end
        ST_G_MUL: begin
          prod_r  <= PW'(size_eff) * PW'(idx_r);
          state_r <= ST_G_ADD;
        end
        ST_G_ADD: begin
          out_valid_r                <= 1'b1;
          out_data_r.ok              <= 1'b1;
          out_data_r.granted_address <= pool_base_r + 32'(prod_r);
          out_data_r.block_index     <= 6'(idx_r);
          state_r                    <= ST_IDLE;
        end
        ST_P_CHK: begin
          if (offset_r >= {9'd0, size_eff, 7'd0}) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '0;
            state_r     <= ST_IDLE;
          end else begin
            rem_r   <= offset_r[22:0];
            dsh_r   <= {1'b0, size_eff, 6'd0};
            q_r     <= '0;
            step_r  <= '0;
            state_r <= ST_P_DIV;
          end
        end
        ST_P_DIV: begin
          if (rem_r >= dsh_r) begin
            rem_r <= rem_r - dsh_r;
            q_r   <= {q_r[5:0], 1'b1};
          end else begin
            q_r <= {q_r[5:0], 1'b0};
          end
          dsh_r  <= dsh_r >> 1;
          step_r <= step_r + 3'd1;
          if (step_r == 3'd6) begin
            state_r <= ST_P_IDX;
          end
        end
        ST_P_IDX: begin
          if (q_r < total) begin
            row_r   <= put_idx[IDX_W-1:fbpa_pkg::BIT_W];
            state_r <= ST_P_WAIT;
          end else begin
            out_valid_r <= 1'b1;
            out_data_r  <= '0;
            state_r     <= ST_IDLE;
          end
        end
        ST_P_WAIT: begin
          state_r <= ST_P_WR;
        end
        ST_P_WR: begin
          free_count_r               <= free_count_r + 7'd1;
          out_valid_r                <= 1'b1;
          out_data_r.ok              <= 1'b1;
          out_data_r.granted_address <= '0;
          out_data_r.block_index     <= 6'(q_r);
          state_r                    <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (cfg_we) begin
        priority case (cfg_index)
          fbpa_pkg::CFG_POOL_BASE: begin
            pool_base_r <= cfg_data;
          end
          fbpa_pkg::CFG_BLOCK_SIZE: begin
            block_size_r <= cfg_data[15:0];
          end
          fbpa_pkg::CFG_BLOCK_COUNT: begin
            block_count_r <= cfg_data[6:0];
            free_count_r  <= clamp_total(cfg_data[6:0]);
            row_r         <= '0;
            state_r       <= ST_CLR;
          end
          default: begin
            pool_base_r <= pool_base_r;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire
